/* hdl/lottery_scheduler_defines.svh */
// Assertion macros shared by the lottery scheduler checker.
`ifndef LOTTERY_SCHEDULER_DEFINES_SVH
`define LOTTERY_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSCH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lottery scheduler check failed");

// Next-cycle implication, disabled during reset.
`define LSCH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lottery scheduler check failed");

`endif

/* hdl/lsch_pkg.sv */
// Shared widths, codes and types of the lottery scheduler.
package lsch_pkg;

    localparam int FUNC_W    = 2;
    localparam int TICKET_W  = 16;
    localparam int RANDOM_W  = 32;
    localparam int PINDEX_W  = 5;
    localparam int STATUS_W  = 2;
    localparam int WINNER_W  = 5;
    localparam int WTICKET_W = 20;
    localparam int WINCNT_W  = 16;

    localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DRAW = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_TICKETS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 2'd3;

    localparam logic [WINCNT_W-1:0] WIN_MAX = 16'hFFFF;

    typedef struct packed {
        logic valid;
        logic draw;
        logic done;
    } tok_ctl_t;

endpackage

/* hdl/lsch_rem.sv */
// Restoring remainder unit that retires one dividend bit per cycle.
module lsch_rem #(
    parameter int DVD_W = 32,
    parameter int DIV_W = 20
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = DIV_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/lsch_cell.sv */
// One process slot: ticket count, win counter and one stage of the scan chain.
module lsch_cell #(
    parameter int TOTAL_W  = 20,
    parameter int IDX_W    = 5,
    parameter int CELL_NUM = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [lsch_pkg::TICKET_W-1:0] wr_data,
    input  lsch_pkg::tok_ctl_t            ctl_i,
    input  logic [TOTAL_W-1:0]            remain_i,
    input  logic [IDX_W-1:0]              idx_i,
    input  logic [lsch_pkg::WINCNT_W-1:0] win_i,
    output lsch_pkg::tok_ctl_t            ctl_o,
    output logic [TOTAL_W-1:0]            remain_o,
    output logic [IDX_W-1:0]              idx_o,
    output logic [lsch_pkg::WINCNT_W-1:0] win_o
);

    localparam logic [IDX_W-1:0] OWN_IDX  = IDX_W'(CELL_NUM);
    localparam logic [IDX_W-1:0] OWN_SLOT = IDX_W'(CELL_NUM - 1);

    logic [lsch_pkg::TICKET_W-1:0] tix_reg, tix_next;
    logic [lsch_pkg::WINCNT_W-1:0] cnt_reg, cnt_next;
    lsch_pkg::tok_ctl_t            ctl_reg, ctl_next;
    logic [TOTAL_W-1:0]            remain_reg, remain_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [lsch_pkg::WINCNT_W-1:0] win_reg, win_next;
    logic [TOTAL_W-1:0]            tix_ext;

    assign tix_ext = TOTAL_W'(tix_reg);

    always_comb begin
        tix_next    = tix_reg;
        cnt_next    = cnt_reg;
        ctl_next    = ctl_i;
        remain_next = remain_i;
        idx_next    = idx_i;
        win_next    = win_i;
        if (wr_en && (wr_addr == OWN_SLOT)) begin
            tix_next = wr_data;
        end
        if (ctl_i.valid && !ctl_i.done) begin
            if (ctl_i.draw) begin
                if (remain_i < tix_ext) begin
                    if (cnt_reg != lsch_pkg::WIN_MAX) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    ctl_next.done = 1'b1;
                    idx_next      = OWN_IDX;
                    win_next      = cnt_next;
                end else begin
                    remain_next = remain_i - tix_ext;
                end
            end else if (idx_i == OWN_IDX) begin
                ctl_next.done = 1'b1;
                win_next      = cnt_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ctl_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            ctl_reg <= ctl_next;
        end
        tix_reg    <= tix_next;
        remain_reg <= remain_next;
        idx_reg    <= idx_next;
        win_reg    <= win_next;
    end

    assign ctl_o    = ctl_reg;
    assign remain_o = remain_reg;
    assign idx_o    = idx_reg;
    assign win_o    = win_reg;

endmodule

/* hdl/lottery_scheduler.sv */
// Top level of the lottery scheduler.
//
//   Channel  Direction  Handshake         Carries
//   s_       in         s_valid/s_ready   func, ticket_count, random_value, process_index
//   m_       out        m_valid/m_ready   status, winner, draw_ticket, win_count
//
// An add or a rejected item goes from idle straight to the done state. A read launches a token
// that walks the chain through one register stage per cell. A draw first runs the remainder
// unit, which retires one bit of the random word per cycle, and then walks the chain the same way.
// Reset is synchronous and active low; it clears the table size, total and win counters.
// A new item is taken while the previous result still waits on m_ready.
module lottery_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lsch_pkg::FUNC_W-1:0]    s_func,
    input  logic [lsch_pkg::TICKET_W-1:0]  s_ticket_count,
    input  logic [lsch_pkg::RANDOM_W-1:0]  s_random_value,
    input  logic [lsch_pkg::PINDEX_W-1:0]  s_process_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lsch_pkg::STATUS_W-1:0]  m_status,
    output logic [lsch_pkg::WINNER_W-1:0]  m_winner,
    output logic [lsch_pkg::WTICKET_W-1:0] m_draw_ticket,
    output logic [lsch_pkg::WINCNT_W-1:0]  m_win_count
);

    localparam int IDX_W   = $clog2(MAX_PROCS + 1);
    localparam int TOTAL_W = lsch_pkg::TICKET_W + $clog2(MAX_PROCS);
    localparam int CMP_W   = (IDX_W > lsch_pkg::PINDEX_W) ? IDX_W : lsch_pkg::PINDEX_W;
    localparam int WHO_W   = (IDX_W > lsch_pkg::WINNER_W) ? IDX_W : lsch_pkg::WINNER_W;
    localparam int TK_W    = (TOTAL_W > lsch_pkg::WTICKET_W) ? TOTAL_W : lsch_pkg::WTICKET_W;
    localparam logic [IDX_W-1:0] CNT_MAX = IDX_W'(MAX_PROCS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [IDX_W-1:0]               count_reg, count_next;
    logic [TOTAL_W-1:0]             total_reg, total_next;
    lsch_pkg::tok_ctl_t             launch_ctl_reg, launch_ctl_next;
    logic [TOTAL_W-1:0]             launch_remain_reg, launch_remain_next;
    logic [IDX_W-1:0]               launch_idx_reg, launch_idx_next;
    logic [lsch_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [lsch_pkg::WINNER_W-1:0]  res_winner_reg, res_winner_next;
    logic [lsch_pkg::WTICKET_W-1:0] res_ticket_reg, res_ticket_next;
    logic [lsch_pkg::WINCNT_W-1:0]  res_win_reg, res_win_next;
    logic                           m_valid_reg, m_valid_next;
    logic [lsch_pkg::STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [lsch_pkg::WINNER_W-1:0]  m_winner_reg, m_winner_next;
    logic [lsch_pkg::WTICKET_W-1:0] m_ticket_reg, m_ticket_next;
    logic [lsch_pkg::WINCNT_W-1:0]  m_win_reg, m_win_next;

    logic               s_fire;
    logic               wr_en;
    logic               div_start;
    logic               div_done;
    logic [TOTAL_W-1:0] div_rem;
    logic               bad_index;
    logic [TK_W-1:0]    tk_ext;
    logic [WHO_W-1:0]   who_ext;

    lsch_pkg::tok_ctl_t            ctl_chain    [MAX_PROCS+1];
    logic [TOTAL_W-1:0]            remain_chain [MAX_PROCS+1];
    logic [IDX_W-1:0]              idx_chain    [MAX_PROCS+1];
    logic [lsch_pkg::WINCNT_W-1:0] win_chain    [MAX_PROCS+1];

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign bad_index = (s_process_index == '0) ||
                       (CMP_W'(s_process_index) > CMP_W'(count_reg));
    assign tk_ext    = TK_W'(div_rem);
    assign who_ext   = WHO_W'(idx_chain[MAX_PROCS]);

    lsch_rem #(
        .DVD_W (lsch_pkg::RANDOM_W),
        .DIV_W (TOTAL_W)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (s_random_value),
        .divisor   (total_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign ctl_chain[0]    = launch_ctl_reg;
    assign remain_chain[0] = launch_remain_reg;
    assign idx_chain[0]    = launch_idx_reg;
    assign win_chain[0]    = '0;

    for (genvar gi = 0; gi < MAX_PROCS; gi++) begin : g_cell
        lsch_cell #(
            .TOTAL_W  (TOTAL_W),
            .IDX_W    (IDX_W),
            .CELL_NUM (gi + 1)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (wr_en),
            .wr_addr  (count_reg),
            .wr_data  (s_ticket_count),
            .ctl_i    (ctl_chain[gi]),
            .remain_i (remain_chain[gi]),
            .idx_i    (idx_chain[gi]),
            .win_i    (win_chain[gi]),
            .ctl_o    (ctl_chain[gi+1]),
            .remain_o (remain_chain[gi+1]),
            .idx_o    (idx_chain[gi+1]),
            .win_o    (win_chain[gi+1])
        );
    end

    always_comb begin
        state_next         = state_reg;
        count_next         = count_reg;
        total_next         = total_reg;
        launch_ctl_next    = '0;
        launch_remain_next = launch_remain_reg;
        launch_idx_next    = launch_idx_reg;
        res_status_next    = res_status_reg;
        res_winner_next    = res_winner_reg;
        res_ticket_next    = res_ticket_reg;
        res_win_next       = res_win_reg;
        m_valid_next       = m_valid_reg;
        m_status_next      = m_status_reg;
        m_winner_next      = m_winner_reg;
        m_ticket_next      = m_ticket_reg;
        m_win_next         = m_win_reg;
        wr_en              = 1'b0;
        div_start          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    res_status_next = lsch_pkg::ST_OK;
                    res_winner_next = '0;
                    res_ticket_next = '0;
                    res_win_next    = '0;
                    state_next      = S_DONE;
                    unique case (s_func)
                        lsch_pkg::FUNC_ADD: begin
                            if (count_reg == CNT_MAX) begin
                                res_status_next = lsch_pkg::ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                total_next = total_reg + TOTAL_W'(s_ticket_count);
                            end
                        end
                        lsch_pkg::FUNC_DRAW: begin
                            if (total_reg == '0) begin
                                res_status_next = lsch_pkg::ST_NO_TICKETS;
                            end else begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        lsch_pkg::FUNC_READ: begin
                            if (bad_index) begin
                                res_status_next = lsch_pkg::ST_BAD_INDEX;
                            end else begin
                                launch_ctl_next.valid = 1'b1;
                                launch_remain_next    = '0;
                                launch_idx_next       = IDX_W'(s_process_index);
                                state_next            = S_SCAN;
                            end
                        end
                        default: begin
                            res_status_next = lsch_pkg::ST_BAD_INDEX;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    launch_ctl_next.valid = 1'b1;
                    launch_ctl_next.draw  = 1'b1;
                    launch_remain_next    = div_rem;
                    launch_idx_next       = '0;
                    res_ticket_next       = tk_ext[lsch_pkg::WTICKET_W-1:0];
                    state_next            = S_SCAN;
                end
            end
            S_SCAN: begin
                if (ctl_chain[MAX_PROCS].valid) begin
                    state_next = S_DONE;
                    if (!ctl_chain[MAX_PROCS].done) begin
                        res_status_next = lsch_pkg::ST_NO_TICKETS;
                        res_winner_next = '0;
                        res_ticket_next = '0;
                        res_win_next    = '0;
                    end else if (ctl_chain[MAX_PROCS].draw) begin
                        res_status_next = lsch_pkg::ST_OK;
                        res_winner_next = who_ext[lsch_pkg::WINNER_W-1:0];
                        res_win_next    = win_chain[MAX_PROCS];
                    end else begin
                        res_status_next = lsch_pkg::ST_OK;
                        res_winner_next = '0;
                        res_ticket_next = '0;
                        res_win_next    = win_chain[MAX_PROCS];
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_winner_next = res_winner_reg;
                    m_ticket_next = res_ticket_reg;
                    m_win_next    = res_win_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            total_reg      <= '0;
            launch_ctl_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            launch_ctl_reg <= launch_ctl_next;
            m_valid_reg    <= m_valid_next;
        end
        launch_remain_reg <= launch_remain_next;
        launch_idx_reg    <= launch_idx_next;
        res_status_reg    <= res_status_next;
        res_winner_reg    <= res_winner_next;
        res_ticket_reg    <= res_ticket_next;
        res_win_reg       <= res_win_next;
        m_status_reg      <= m_status_next;
        m_winner_reg      <= m_winner_next;
        m_ticket_reg      <= m_ticket_next;
        m_win_reg         <= m_win_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_winner      = m_winner_reg;
    assign m_draw_ticket = m_ticket_reg;
    assign m_win_count   = m_win_reg;

endmodule

/* hdl/lsch_checker.sv */
// Port-level checker for the lottery scheduler and its bind statement.
`include "lottery_scheduler_defines.svh"

module lsch_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [lsch_pkg::FUNC_W-1:0]    s_func,
    input logic [lsch_pkg::TICKET_W-1:0]  s_ticket_count,
    input logic [lsch_pkg::RANDOM_W-1:0]  s_random_value,
    input logic [lsch_pkg::PINDEX_W-1:0]  s_process_index,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [lsch_pkg::STATUS_W-1:0]  m_status,
    input logic [lsch_pkg::WINNER_W-1:0]  m_winner,
    input logic [lsch_pkg::WTICKET_W-1:0] m_draw_ticket,
    input logic [lsch_pkg::WINCNT_W-1:0]  m_win_count
);

    // A stalled input transaction keeps its payload.
    `LSCH_ASSERT_NXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_func) && $stable(s_ticket_count) && $stable(s_random_value) && $stable(s_process_index))

    // A stalled result transaction keeps its payload.
    `LSCH_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_winner) && $stable(m_draw_ticket) && $stable(m_win_count))

    // Every error status carries all-zero result fields.
    `LSCH_ASSERT_IMP(a_err_zero, aclk, aresetn, m_valid && (m_status != lsch_pkg::ST_OK), (m_winner == '0) && (m_draw_ticket == '0) && (m_win_count == '0))

    // A named winner has just been counted, so its win count is never zero.
    `LSCH_ASSERT_IMP(a_win_nonzero, aclk, aresetn, m_valid && (m_winner != '0), (m_status == lsch_pkg::ST_OK) && (m_win_count != '0))

    // A winning ticket only comes with a winner.
    `LSCH_ASSERT_IMP(a_ticket_needs_winner, aclk, aresetn, m_valid && (m_winner == '0), m_draw_ticket == '0)

endmodule

bind lottery_scheduler lsch_checker u_lsch_checker (.*);
